@@ hdl/ac_remote_ir_frame_serializer_defines.svh @@
// ============================================================================
// Assertion macros for the IR frame serializer
// Shared property shapes used by the checker that watches the top level.
// ============================================================================
`ifndef AC_REMOTE_IR_FRAME_SERIALIZER_DEFINES_SVH
`define AC_REMOTE_IR_FRAME_SERIALIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define ACIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("IR serializer check failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define ACIR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("IR serializer check failed");

`endif

@@ hdl/acir_pkg.sv @@
// ============================================================================
// IR frame serializer package
// Shared types, constants and the frame builder function.
// ============================================================================
`default_nettype none

package acir_pkg;

	// Frame geometry.
	localparam int FRAME_BYTES  = 13;
	localparam int TIMING_COUNT = 2 + 16 * FRAME_BYTES + 1;
	localparam int POS_W        = $clog2(TIMING_COUNT);
	localparam int DUR_W        = 16;
	localparam int TEMP_W       = 6;
	localparam int CFG_IDX_W    = 3;

	// Fixed frame bytes.
	localparam logic [7:0] PREAMBLE_BYTE = 8'hC3;
	localparam logic [7:0] TRAILER_BYTE  = 8'h1E;
	localparam logic [7:0] SWING_V_OFF   = 8'h07;
	localparam logic [7:0] SWING_H_OFF   = 8'hE0;
	localparam logic [7:0] POWER_ON      = 8'h20;
	localparam logic [7:0] TEMP_OFFSET   = 8'd8;

	// Reset values of the configuration registers.
	localparam logic [TEMP_W-1:0] TEMP_MIN_RST  = 6'd16;
	localparam logic [TEMP_W-1:0] TEMP_MAX_RST  = 6'd32;
	localparam logic [DUR_W-1:0]  LEAD_ON_RST   = 16'd9000;
	localparam logic [DUR_W-1:0]  LEAD_OFF_RST  = 16'd4500;
	localparam logic [DUR_W-1:0]  PULSE_ON_RST  = 16'd575;
	localparam logic [DUR_W-1:0]  GAP_ONE_RST   = 16'd1675;
	localparam logic [DUR_W-1:0]  GAP_ZERO_RST  = 16'd550;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP_MIN = 3'd0,
		CFG_TEMP_MAX = 3'd1,
		CFG_LEAD_ON  = 3'd2,
		CFG_LEAD_OFF = 3'd3,
		CFG_PULSE_ON = 3'd4,
		CFG_GAP_ONE  = 3'd5,
		CFG_GAP_ZERO = 3'd6
	} cfg_idx_t;

	// Command carried with every input item.
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_t;

	// Mode and fan codes of the input fields.
	typedef enum logic [2:0] {
		MODE_OFF  = 3'd0,
		MODE_COOL = 3'd1,
		MODE_AUTO = 3'd2,
		MODE_DRY  = 3'd3,
		MODE_HEAT = 3'd4,
		MODE_FAN  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		FAN_AUTO = 3'd0,
		FAN_LOW  = 3'd1,
		FAN_MED  = 3'd2,
		FAN_HIGH = 3'd3
	} fan_t;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	// Settings of one start request.
	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] fan;
		logic [7:0] temp;
		logic       swing_v;
		logic       swing_h;
		logic       power;
	} frame_req_t;

	// Timing configuration as seen by the sequencer.
	typedef struct packed {
		logic [DUR_W-1:0] lead_on;
		logic [DUR_W-1:0] lead_off;
		logic [DUR_W-1:0] pulse_on;
		logic [DUR_W-1:0] gap_one;
		logic [DUR_W-1:0] gap_zero;
	} timing_cfg_t;

	// Control from the sequencer to the byte chain.
	typedef struct packed {
		logic load;
		logic shift;
	} chain_ctrl_t;

	// One result item.
	typedef struct packed {
		logic [DUR_W-1:0] duration_us;
		logic             is_mark;
		logic             last;
		logic             status;
	} result_t;

	// Mode byte; unknown modes fall back to cool.
	function automatic logic [7:0] mode_code(input logic [2:0] mode);
		logic [7:0] code;
		unique case (mode)
			MODE_OFF:  code = 8'h00;
			MODE_COOL: code = 8'h20;
			MODE_AUTO: code = 8'h00;
			MODE_DRY:  code = 8'h40;
			MODE_HEAT: code = 8'h80;
			MODE_FAN:  code = 8'hC0;
			default:   code = 8'h20;
		endcase
		return code;
	endfunction

	// Fan byte; unknown speeds fall back to auto.
	function automatic logic [7:0] fan_code(input logic [2:0] fan);
		logic [7:0] code;
		unique case (fan)
			FAN_AUTO: code = 8'hA0;
			FAN_LOW:  code = 8'h60;
			FAN_MED:  code = 8'h40;
			FAN_HIGH: code = 8'h20;
			default:  code = 8'hA0;
		endcase
		return code;
	endfunction

	// Build the whole frame, checksum in the last byte.
	function automatic frame_t build_frame(input frame_req_t req,
			input logic [TEMP_W-1:0] tmin, input logic [TEMP_W-1:0] tmax);
		frame_t     f;
		logic [7:0] t;
		logic [7:0] t_off;
		logic [7:0] sum;
		t = req.temp;
		if (t < {2'b00, tmin})
			t = {2'b00, tmin};
		if (t > {2'b00, tmax})
			t = {2'b00, tmax};
		t_off = t - TEMP_OFFSET;
		f     = '0;
		f[0]  = PREAMBLE_BYTE;
		f[1]  = {t_off[4:0], 3'b000} | (req.swing_v ? 8'h00 : SWING_V_OFF);
		f[2]  = req.swing_h ? 8'h00 : SWING_H_OFF;
		f[4]  = fan_code(req.fan);
		f[6]  = mode_code(req.mode);
		f[9]  = req.power ? POWER_ON : 8'h00;
		f[11] = TRAILER_BYTE;
		sum   = '0;
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			sum = sum + f[i];
		f[FRAME_BYTES-1] = sum;
		return f;
	endfunction

endpackage

`default_nettype wire

@@ hdl/acir_cell.sv @@
// ============================================================================
// Byte cell of the frame chain
// Holds one frame byte; loads it in parallel and shifts it out bit by bit.
// ============================================================================
`default_nettype none

module acir_cell (
	input  wire logic                 clk,
	input  wire acir_pkg::chain_ctrl_t ctrl,
	input  wire logic [7:0]           load_byte,
	input  wire logic                 shift_in,
	output logic                      shift_out
);
	import acir_pkg::*;

	logic [7:0] byte_q;

	// Load wins over shift; the upper neighbor feeds the top bit.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= load_byte;
		end else if (ctrl.shift) begin
			byte_q <= {shift_in, byte_q[7:1]};
		end
	end

	assign shift_out = byte_q[0];

endmodule

`default_nettype wire

@@ hdl/acir_chain.sv @@
// ============================================================================
// Frame chain
// A row of byte cells; the lowest cell presents the next frame bit.
// ============================================================================
`default_nettype none

module acir_chain (
	input  wire logic                  clk,
	input  wire acir_pkg::chain_ctrl_t ctrl,
	input  wire acir_pkg::frame_t      frame,
	output logic                       cur_bit
);
	import acir_pkg::*;

	logic [FRAME_BYTES:0] link;

	// Zeros enter at the top end of the chain.
	assign link[FRAME_BYTES] = 1'b0;

	for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
		acir_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_byte (frame[i]),
			.shift_in  (link[i+1]),
			.shift_out (link[i])
		);
	end

	assign cur_bit = link[0];

endmodule

`default_nettype wire

@@ hdl/acir_seq.sv @@
// ============================================================================
// Timing sequencer
// Tracks the position in the frame and picks the timing for each fetch.
// ============================================================================
`default_nettype none

module acir_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic                  cmd,
	input  wire logic                  cur_bit,
	input  wire acir_pkg::timing_cfg_t tcfg,
	output acir_pkg::chain_ctrl_t      ctrl,
	output logic                       res_valid,
	output acir_pkg::result_t          res
);
	import acir_pkg::*;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(TIMING_COUNT - 1);

	logic [POS_W-1:0] pos_q;
	logic             active_q;
	logic             is_start;
	logic             is_fetch;
	logic             at_last;

	assign is_start = accept && (cmd == CMD_START);
	assign is_fetch = accept && (cmd == CMD_FETCH);
	assign at_last  = (pos_q == POS_LAST);

	// Choose the timing for the current position.
	always_comb begin
		res       = '0;
		ctrl      = '0;
		res_valid = is_fetch;
		ctrl.load = is_start;
		if (!active_q) begin
			res.status = 1'b1;
		end else if (pos_q == '0) begin
			res.duration_us = tcfg.lead_on;
			res.is_mark     = 1'b1;
		end else if (pos_q == POS_W'(1)) begin
			res.duration_us = tcfg.lead_off;
		end else if (at_last) begin
			res.duration_us = tcfg.pulse_on;
			res.is_mark     = 1'b1;
			res.last        = 1'b1;
		end else if (!pos_q[0]) begin
			res.duration_us = tcfg.pulse_on;
			res.is_mark     = 1'b1;
		end else begin
			res.duration_us = cur_bit ? tcfg.gap_one : tcfg.gap_zero;
			ctrl.shift      = is_fetch;
		end
	end

	// Position and frame activity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			active_q <= 1'b0;
		end else if (is_start) begin
			pos_q    <= '0;
			active_q <= 1'b1;
		end else if (is_fetch && active_q) begin
			if (at_last) begin
				pos_q    <= '0;
				active_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/ac_remote_ir_frame_serializer.sv @@
// ============================================================================
// IR remote frame serializer
// Builds an air-conditioner IR frame and streams its mark and space timings.
// ============================================================================
// The block takes one input transfer in every cycle while the skid register
// is empty. A start transfer (tuser 0) loads the 13-byte frame into a row of
// byte cells and gives no result; each fetch transfer (tuser 1) gives one
// timing result: header mark, header space, a mark and a space for each of
// the 104 frame bits least significant first, then a trailing mark with
// tlast set, 211 results per frame. The cells shift the frame one bit per
// data space, so the lowest cell always holds the next bit. A fetch with no
// frame active returns tuser 1 and zero data. Results leave through an
// output register backed by a skid register, so the input side keeps running
// into the skid register at the first output stall and then holds tready
// low until it drains. Configuration writes take effect on the next cycle.
`default_nettype none

module ac_remote_ir_frame_serializer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // mode[2:0], fan[5:3], temp[13:6], swing_v[14],
	                                   // swing_h[15], power[16], zero fill[23:17]
	input  wire logic        s_tuser,  // cmd[0]
	// Output stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // duration_us[15:0], is_mark[16], zero fill[23:17]
	output logic             m_tuser,  // status[0]
	output logic             m_tlast
);
	import acir_pkg::*;

	logic [TEMP_W-1:0] temp_min_q;
	logic [TEMP_W-1:0] temp_max_q;
	timing_cfg_t       tcfg_q;
	frame_req_t        req;
	frame_t            frame;
	chain_ctrl_t       ctrl;
	logic              accept;
	logic              cur_bit;
	logic              res_valid;
	result_t           res;
	result_t           out_q;
	result_t           skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_min_q      <= TEMP_MIN_RST;
			temp_max_q      <= TEMP_MAX_RST;
			tcfg_q.lead_on  <= LEAD_ON_RST;
			tcfg_q.lead_off <= LEAD_OFF_RST;
			tcfg_q.pulse_on <= PULSE_ON_RST;
			tcfg_q.gap_one  <= GAP_ONE_RST;
			tcfg_q.gap_zero <= GAP_ZERO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEMP_MIN: temp_min_q      <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_MAX: temp_max_q      <= cfg_data[TEMP_W-1:0];
				CFG_LEAD_ON:  tcfg_q.lead_on  <= cfg_data;
				CFG_LEAD_OFF: tcfg_q.lead_off <= cfg_data;
				CFG_PULSE_ON: tcfg_q.pulse_on <= cfg_data;
				CFG_GAP_ONE:  tcfg_q.gap_one  <= cfg_data;
				CFG_GAP_ZERO: tcfg_q.gap_zero <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the input item and build the frame bytes.
	assign req.mode    = s_tdata[2:0];
	assign req.fan     = s_tdata[5:3];
	assign req.temp    = s_tdata[13:6];
	assign req.swing_v = s_tdata[14];
	assign req.swing_h = s_tdata[15];
	assign req.power   = s_tdata[16];
	assign frame       = build_frame(req, temp_min_q, temp_max_q);

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;

	acir_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (s_tuser),
		.cur_bit   (cur_bit),
		.tcfg      (tcfg_q),
		.ctrl      (ctrl),
		.res_valid (res_valid),
		.res       (res)
	);

	acir_chain u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.frame   (frame),
		.cur_bit (cur_bit)
	);

	// Output register with a skid register behind it.
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= res_valid;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.is_mark, out_q.duration_us};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

@@ hdl/acir_checker.sv @@
// ============================================================================
// IR frame serializer checker
// Port-level checks on the result stream, bound to the top level.
// ============================================================================
`default_nettype none

`include "ac_remote_ir_frame_serializer_defines.svh"

module acir_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// A stalled result holds its payload.
	`ACIR_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// An error status carries no timing.
	`ACIR_ASSERT_IMP(a_err_empty, clk, arst_n, m_tvalid && m_tuser, (m_tdata == 24'd0) && !m_tlast)

	// The frame ends on a valid mark.
	`ACIR_ASSERT_IMP(a_last_mark, clk, arst_n, m_tvalid && m_tlast, m_tdata[16] && !m_tuser)

	// The result after a trailing mark is never another trailing mark.
	`ACIR_ASSERT_NXT(a_last_gap, clk, arst_n, m_tvalid && m_tready && m_tlast, !(m_tvalid && m_tlast))

endmodule

bind ac_remote_ir_frame_serializer acir_checker u_acir_checker (.*);

`default_nettype wire
